FILE: rtl/core/ps2_set2_keyboard_decoder_fifo_assert.svh
// ----------------------------------------------------------------------------
// PS/2 keyboard decoder assertion macros
// Clocked concurrent assertion helpers, compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef PS2_SET2_KEYBOARD_DECODER_FIFO_ASSERT_SVH
`define PS2_SET2_KEYBOARD_DECODER_FIFO_ASSERT_SVH

`ifndef ASSERT_OFF
// prop must hold on every edge outside reset
`define PS2KD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// cause implies effect in the next cycle
`define PS2KD_ASSERT_NEXT(label, clk, rst_n, cause, effect, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
    else $error(msg);
`else
`define PS2KD_ASSERT(label, clk, rst_n, prop, msg)
`define PS2KD_ASSERT_NEXT(label, clk, rst_n, cause, effect, msg)
`endif

`endif

FILE: rtl/core/ps2kd_pkg.sv
// ----------------------------------------------------------------------------
// ps2kd_pkg
// Shared constants, op codes, queue entry type and key maps for the decoder.
// ----------------------------------------------------------------------------
package ps2kd_pkg;

  localparam int FIFO_DEPTH  = 256;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int CHAR_W      = 7;

  localparam logic [7:0] CODE_RELEASE = 8'hF0;
  localparam logic [7:0] CODE_LSHIFT  = 8'h12;
  localparam logic [7:0] CODE_RSHIFT  = 8'h59;

  typedef logic [1:0] op_t;
  localparam op_t OP_NONE = 2'd0;
  localparam op_t OP_READ = 2'd1;
  localparam op_t OP_PUSH = 2'd2;

  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] ch;
  } q_entry_t;

  function automatic logic [CHAR_W-1:0] plain_char(input logic [7:0] code);
    logic [CHAR_W-1:0] c;
    case (code)
      8'h0D: c = 7'h09; 8'h0E: c = 7'h60; 8'h15: c = 7'h71; 8'h16: c = 7'h31;
      8'h1A: c = 7'h7A; 8'h1B: c = 7'h73; 8'h1C: c = 7'h61; 8'h1D: c = 7'h77;
      8'h1E: c = 7'h32; 8'h21: c = 7'h63; 8'h22: c = 7'h78; 8'h23: c = 7'h64;
      8'h24: c = 7'h65; 8'h25: c = 7'h34; 8'h26: c = 7'h33; 8'h29: c = 7'h20;
      8'h2A: c = 7'h76; 8'h2B: c = 7'h66; 8'h2C: c = 7'h74; 8'h2D: c = 7'h72;
      8'h2E: c = 7'h35; 8'h31: c = 7'h6E; 8'h32: c = 7'h62; 8'h33: c = 7'h68;
      8'h34: c = 7'h67; 8'h35: c = 7'h79; 8'h36: c = 7'h36; 8'h3A: c = 7'h6D;
      8'h3B: c = 7'h6A; 8'h3C: c = 7'h75; 8'h3D: c = 7'h37; 8'h3E: c = 7'h38;
      8'h41: c = 7'h2C; 8'h42: c = 7'h6B; 8'h43: c = 7'h69; 8'h44: c = 7'h6F;
      8'h45: c = 7'h30; 8'h46: c = 7'h39; 8'h49: c = 7'h2E; 8'h4A: c = 7'h2F;
      8'h4B: c = 7'h6C; 8'h4C: c = 7'h3B; 8'h4D: c = 7'h70; 8'h4E: c = 7'h2D;
      8'h52: c = 7'h27; 8'h54: c = 7'h5B; 8'h55: c = 7'h3D; 8'h5A: c = 7'h0A;
      8'h5B: c = 7'h5D; 8'h5D: c = 7'h5C;
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] shift_char(input logic [7:0] code);
    logic [CHAR_W-1:0] c;
    case (code)
      8'h0D: c = 7'h09; 8'h0E: c = 7'h7E; 8'h15: c = 7'h51; 8'h16: c = 7'h21;
      8'h1A: c = 7'h5A; 8'h1B: c = 7'h53; 8'h1C: c = 7'h41; 8'h1D: c = 7'h57;
      8'h1E: c = 7'h40; 8'h21: c = 7'h43; 8'h22: c = 7'h58; 8'h23: c = 7'h44;
      8'h24: c = 7'h45; 8'h25: c = 7'h24; 8'h26: c = 7'h23; 8'h29: c = 7'h20;
      8'h2A: c = 7'h56; 8'h2B: c = 7'h46; 8'h2C: c = 7'h54; 8'h2D: c = 7'h52;
      8'h2E: c = 7'h25; 8'h31: c = 7'h4E; 8'h32: c = 7'h42; 8'h33: c = 7'h48;
      8'h34: c = 7'h47; 8'h35: c = 7'h59; 8'h36: c = 7'h5E; 8'h3A: c = 7'h4D;
      8'h3B: c = 7'h4A; 8'h3C: c = 7'h55; 8'h3D: c = 7'h26; 8'h3E: c = 7'h2A;
      8'h41: c = 7'h3C; 8'h42: c = 7'h4B; 8'h43: c = 7'h49; 8'h44: c = 7'h4F;
      8'h45: c = 7'h29; 8'h46: c = 7'h28; 8'h49: c = 7'h3E; 8'h4A: c = 7'h3F;
      8'h4B: c = 7'h4C; 8'h4C: c = 7'h3A; 8'h4D: c = 7'h50; 8'h4E: c = 7'h5F;
      8'h52: c = 7'h22; 8'h54: c = 7'h7B; 8'h55: c = 7'h2B; 8'h5A: c = 7'h0A;
      8'h5B: c = 7'h7D; 8'h5D: c = 7'h7C;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/ps2kd_ram.sv
// ----------------------------------------------------------------------------
// ps2kd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ps2kd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/ps2kd_front.sv
// ----------------------------------------------------------------------------
// ps2kd_front
// Accepts scan bytes and read requests, tracks release and shift state and
// turns each beat into one queued op.
// ----------------------------------------------------------------------------
module ps2kd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_req_type,
  input  logic [7:0]          in_scan_byte,
  input  logic                q_full,
  output logic                q_push,
  output ps2kd_pkg::q_entry_t q_entry
);

  logic release_r, release_nxt;
  logic lshift_r, lshift_nxt;
  logic rshift_r, rshift_nxt;
  logic [ps2kd_pkg::CHAR_W-1:0] plain_c;
  logic [ps2kd_pkg::CHAR_W-1:0] shift_c;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;
  assign plain_c  = ps2kd_pkg::plain_char(in_scan_byte);
  assign shift_c  = ps2kd_pkg::shift_char(in_scan_byte);

  always_comb begin
    release_nxt = release_r;
    lshift_nxt  = lshift_r;
    rshift_nxt  = rshift_r;
    q_entry.op  = ps2kd_pkg::OP_NONE;
    q_entry.ch  = '0;
    if (in_req_type) begin
      q_entry.op = ps2kd_pkg::OP_READ;
    end else if (release_r) begin
      // byte after a break code is the released key, whatever it is
      release_nxt = 1'b0;
      if (in_scan_byte == ps2kd_pkg::CODE_LSHIFT) begin
        lshift_nxt = 1'b0;
      end else if (in_scan_byte == ps2kd_pkg::CODE_RSHIFT) begin
        rshift_nxt = 1'b0;
      end
    end else if (in_scan_byte == ps2kd_pkg::CODE_RELEASE) begin
      release_nxt = 1'b1;
    end else begin
      if (in_scan_byte == ps2kd_pkg::CODE_LSHIFT) begin
        lshift_nxt = 1'b1;
      end else if (in_scan_byte == ps2kd_pkg::CODE_RSHIFT) begin
        rshift_nxt = 1'b1;
      end
      if (plain_c != '0) begin
        q_entry.op = ps2kd_pkg::OP_PUSH;
        q_entry.ch = (lshift_r || rshift_r) ? shift_c : plain_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      release_r <= 1'b0;
      lshift_r  <= 1'b0;
      rshift_r  <= 1'b0;
    end else if (q_push) begin
      release_r <= release_nxt;
      lshift_r  <= lshift_nxt;
      rshift_r  <= rshift_nxt;
    end
  end

endmodule

FILE: rtl/core/ps2kd_opq.sv
// ----------------------------------------------------------------------------
// ps2kd_opq
// Short register queue of decoded ops between front and back.
// ----------------------------------------------------------------------------
module ps2kd_opq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ps2kd_pkg::q_entry_t push_entry,
  output logic                full,
  output logic                head_valid,
  output ps2kd_pkg::q_entry_t head_entry,
  input  logic                pop
);

  localparam int LAST = ps2kd_pkg::QUEUE_DEPTH - 1;

  ps2kd_pkg::q_entry_t             slot_r [ps2kd_pkg::QUEUE_DEPTH];
  logic [ps2kd_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [ps2kd_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [ps2kd_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;

  assign full       = (cnt_r == ps2kd_pkg::QCNT_W'(ps2kd_pkg::QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_entry = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == ps2kd_pkg::QPTR_W'(LAST)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == ps2kd_pkg::QPTR_W'(LAST)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/core/ps2kd_back.sv
// ----------------------------------------------------------------------------
// ps2kd_back
// Runs queued ops against the character FIFO and presents one result beat
// per op from a registered output stage.
// ----------------------------------------------------------------------------
`include "ps2_set2_keyboard_decoder_fifo_assert.svh"

module ps2kd_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_valid,
  input  ps2kd_pkg::q_entry_t              q_entry,
  output logic                             q_pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ps2kd_pkg::CHAR_W-1:0]     out_char,
  output logic                             out_char_valid,
  output logic                             out_fifo_empty,
  output logic                             out_dropped
);

  localparam int LAST = ps2kd_pkg::FIFO_DEPTH - 1;

  logic [ps2kd_pkg::PTR_W-1:0]  wptr_r, wptr_nxt;
  logic [ps2kd_pkg::PTR_W-1:0]  rptr_r, rptr_nxt;
  logic [ps2kd_pkg::PTR_W-1:0]  wnext;
  logic [ps2kd_pkg::PTR_W-1:0]  rnext;
  logic                         pend_valid_r, pend_valid_nxt;
  logic                         pend_pop_r, pend_empty_r, pend_drop_r;
  logic                         fire, is_read, is_push, is_empty, is_full;
  logic                         ram_we, ram_re;
  logic [ps2kd_pkg::CHAR_W-1:0] ram_rdata;

  assign wnext    = (wptr_r == ps2kd_pkg::PTR_W'(LAST)) ? '0 : wptr_r + 1'b1;
  assign rnext    = (rptr_r == ps2kd_pkg::PTR_W'(LAST)) ? '0 : rptr_r + 1'b1;
  assign is_read  = (q_entry.op == ps2kd_pkg::OP_READ);
  assign is_push  = (q_entry.op == ps2kd_pkg::OP_PUSH);
  assign is_empty = (wptr_r == rptr_r);
  assign is_full  = (wnext == rptr_r);

  // output stage is free, or its beat leaves this cycle
  assign fire   = q_valid && (!pend_valid_r || out_ready);
  assign q_pop  = fire;
  assign ram_we = fire && is_push && !is_full;
  assign ram_re = fire && is_read && !is_empty;

  always_comb begin
    wptr_nxt       = ram_we ? wnext : wptr_r;
    rptr_nxt       = ram_re ? rnext : rptr_r;
    pend_valid_nxt = pend_valid_r;
    if (fire) begin
      pend_valid_nxt = 1'b1;
    end else if (out_ready) begin
      pend_valid_nxt = 1'b0;
    end
  end

  ps2kd_ram #(
    .WIDTH (ps2kd_pkg::CHAR_W),
    .DEPTH (ps2kd_pkg::FIFO_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wptr_r),
    .wdata (q_entry.ch),
    .re    (ram_re),
    .raddr (rptr_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r       <= '0;
      rptr_r       <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      wptr_r       <= wptr_nxt;
      rptr_r       <= rptr_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pend_pop_r   <= is_read && !is_empty;
      pend_empty_r <= is_read && is_empty;
      pend_drop_r  <= is_push && is_full;
    end
  end

  // read data register holds while the beat is stalled: no read fires then
  assign out_valid      = pend_valid_r;
  assign out_char       = pend_pop_r ? ram_rdata : '0;
  assign out_char_valid = pend_pop_r;
  assign out_fifo_empty = pend_empty_r;
  assign out_dropped    = pend_drop_r;

  `PS2KD_ASSERT(a_flags_exclusive, clk, rst_n,
                !pend_valid_r || $onehot0({pend_pop_r, pend_empty_r, pend_drop_r}),
                "more than one result flag set")
  `PS2KD_ASSERT(a_ptr_range, clk, rst_n,
                (wptr_r <= ps2kd_pkg::PTR_W'(LAST)) && (rptr_r <= ps2kd_pkg::PTR_W'(LAST)),
                "FIFO pointer out of range")
  `PS2KD_ASSERT_NEXT(a_pop_moves_rptr, clk, rst_n, ram_re,
                     rptr_r != $past(rptr_r) && wptr_r == $past(wptr_r),
                     "pop did not advance read pointer alone")
  `PS2KD_ASSERT_NEXT(a_fire_gives_beat, clk, rst_n, fire, pend_valid_r,
                     "executed op produced no result beat")

endmodule

FILE: rtl/core/ps2_set2_keyboard_decoder_fifo.sv
// ----------------------------------------------------------------------------
// ps2_set2_keyboard_decoder_fifo
// PS/2 set 2 scan byte decoder with an ASCII character FIFO.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): in_req_type 0 carries a scan byte from
// the keyboard in in_scan_byte, 1 is a consumer read request.
// Output channel (out_valid/out_ready): exactly one beat per input beat, in
// order. A read returns out_char with out_char_valid, or out_fifo_empty; a
// key press that finds the FIFO full returns out_dropped; anything else
// returns an all-zero beat.
// An accepted beat passes the op queue, then the registered output stage.
// Throughput: one beat per cycle while out_ready is high, set by the back
// stage, running one queued op per cycle on separate write and read ports.
// Reset (rst_n low, synchronous) clears shift and release state, the op
// queue and both FIFO pointers; FIFO storage is not cleared.
// When the receiver stalls, the output beat holds, the two-entry op queue
// fills, and in_ready drops once it is full.
// ----------------------------------------------------------------------------
module ps2_set2_keyboard_decoder_fifo (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_req_type,
  input  logic [7:0]                   in_scan_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ps2kd_pkg::CHAR_W-1:0] out_char,
  output logic                         out_char_valid,
  output logic                         out_fifo_empty,
  output logic                         out_dropped
);

  ps2kd_pkg::q_entry_t push_entry;
  ps2kd_pkg::q_entry_t head_entry;
  logic                q_full, q_push, head_valid, q_pop;

  ps2kd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_req_type  (in_req_type),
    .in_scan_byte (in_scan_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (push_entry)
  );

  ps2kd_opq u_opq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (q_pop)
  );

  ps2kd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (head_valid),
    .q_entry        (head_entry),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char       (out_char),
    .out_char_valid (out_char_valid),
    .out_fifo_empty (out_fifo_empty),
    .out_dropped    (out_dropped)
  );

endmodule
